// File: sv/lpfc_pkg.sv
package lpfc_pkg;

   // Conversion codes carried with each transaction
   typedef enum logic [3:0] {
      FUNC_BF16_TRUNC = 4'd0,
      FUNC_BF16_HALF  = 4'd1,
      FUNC_BF16_RNE   = 4'd2,
      FUNC_F16_RNE    = 4'd3,
      FUNC_HF8        = 4'd4,
      FUNC_BF8        = 4'd5,
      FUNC_BF16_UP    = 4'd6,
      FUNC_F16_UP     = 4'd7,
      FUNC_HF8_UP     = 4'd8,
      FUNC_BF8_UP     = 4'd9
   } lpfc_func_type;

   // Exponent biases
   localparam logic [7:0] SGL_EXP_BIAS  = 8'd127;
   localparam logic [7:0] HALF_EXP_BIAS = 8'd15;
   localparam logic [7:0] HF8_BIAS      = 8'd7;

   // fp32 -> fp16 exponent thresholds (in fp32 biased exponent)
   localparam logic [7:0] F16_EXP_OVF  = SGL_EXP_BIAS + HALF_EXP_BIAS;          // 142
   localparam logic [7:0] F16_EXP_SUB  = SGL_EXP_BIAS - HALF_EXP_BIAS;          // 112
   localparam logic [7:0] F16_EXP_ZERO = SGL_EXP_BIAS - HALF_EXP_BIAS - 8'd10;  // 102

   // fp16 -> hf8 exponent thresholds (in fp16 biased exponent)
   localparam logic [4:0] HF8_EXP_OVF  = 5'(HALF_EXP_BIAS - HF8_BIAS + HALF_EXP_BIAS); // 23
   localparam logic [4:0] HF8_EXP_SUB  = 5'(HALF_EXP_BIAS - HF8_BIAS);                 // 8
   localparam logic [4:0] HF8_EXP_ZERO = 5'(HALF_EXP_BIAS - HF8_BIAS - 8'd3);          // 5
   localparam logic [9:0] HF8_FR_MAX   = 10'h300;

   // Common bit patterns
   localparam logic [31:0] F32_QUIET_BIT = 32'h0040_0000;
   localparam logic [9:0]  F16_QUIET_BIT = 10'h200;

endpackage

// File: sv/low_precision_float_converter.sv
// A request is held in the input register, then the fp16 rounding register,
// then the output register, whose valid bit is rsp_valid.
// Throughput: one transaction per cycle while rsp_ready is high; three register stages
// (input, fp16 rounding, narrow rounding / up-conversion) each take one item per clock.
// Ready ripples back through the stage valid bits, so bubbles are squeezed out.
// Reset (synchronous, active high) empties all stages; data registers are not reset.
module low_precision_float_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_func,
   input  logic [31:0] req_src_bits,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_dst_bits
);
   import lpfc_pkg::*;

   logic          s1_valid_ff, s1_valid_in;
   lpfc_func_type s1_func_ff, s1_func_in;
   logic [31:0]   s1_src_ff, s1_src_in;

   logic          s2_valid_ff, s2_valid_in;
   lpfc_func_type s2_func_ff, s2_func_in;
   logic [31:0]   s2_wide_ff, s2_wide_in;
   logic [15:0]   s2_half_ff, s2_half_in;
   logic [15:0]   s2_src_ff, s2_src_in;

   logic          s3_valid_ff, s3_valid_in;
   logic [31:0]   s3_dst_ff, s3_dst_in;

   logic          s1_ready, s2_ready, s3_ready;

   logic [31:0]   x;
   logic [31:0]   x_quiet;
   logic [31:0]   x_round;
   logic [15:0]   bf_up;

   // Stage ready: a stage can load when empty or when its content moves on
   assign s3_ready  = !s3_valid_ff || rsp_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;

   // Stage 1 capture
   assign s1_valid_in = s1_ready ? req_valid : s1_valid_ff;
   assign s1_func_in  = s1_ready ? lpfc_func_type'(req_func) : s1_func_ff;
   assign s1_src_in   = s1_ready ? req_src_bits : s1_src_ff;

   // Stage 1 logic: bf16 paths and fp32 -> fp16 rounding
   always_comb begin
      x       = (s1_src_ff[30:23] == 8'd0) ? {s1_src_ff[31], 31'd0} : s1_src_ff;
      x_quiet = (x[22:0] == 23'd0) ? x : (x | F32_QUIET_BIT);
      bf_up   = (s1_src_ff[14:7] == 8'd0) ? {s1_src_ff[15], 15'd0} : s1_src_ff[15:0];
      case (s1_func_ff)
         FUNC_BF16_TRUNC: x_round = x;
         FUNC_BF16_HALF:  x_round = x + 32'h0000_8000;
         FUNC_BF16_RNE:   x_round = x + 32'h0000_7fff + {31'd0, x[16]};
         default:         x_round = x;
      endcase
      if (x[30:23] == 8'hff) begin
         x_round = x_quiet;
      end
      if (s1_func_ff == FUNC_BF16_UP) begin
         s2_wide_in = {bf_up, 16'd0};
      end else begin
         s2_wide_in = {16'd0, x_round[31:16]};
      end
      if (!s2_ready) begin
         s2_wide_in = s2_wide_ff;
      end
   end

   logic [15:0] half_bits;

   lpfc_f32_f16 u_f32_f16 (
      .src_bits  (s1_src_ff),
      .half_bits (half_bits)
   );

   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
   assign s2_func_in  = s2_ready ? s1_func_ff : s2_func_ff;
   assign s2_half_in  = s2_ready ? half_bits : s2_half_ff;
   assign s2_src_in   = s2_ready ? s1_src_ff[15:0] : s2_src_ff;

   // Stage 2 logic: fp8 rounding and up-conversions
   logic [31:0] dst_bits;

   lpfc_narrow u_narrow (
      .func      (s2_func_ff),
      .wide_bits (s2_wide_ff),
      .half_bits (s2_half_ff),
      .src_low   (s2_src_ff),
      .dst_bits  (dst_bits)
   );

   assign s3_valid_in = s3_ready ? s2_valid_ff : s3_valid_ff;
   assign s3_dst_in   = s3_ready ? dst_bits : s3_dst_ff;

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_func_ff <= s1_func_in;
      s1_src_ff  <= s1_src_in;
      s2_func_ff <= s2_func_in;
      s2_wide_ff <= s2_wide_in;
      s2_half_ff <= s2_half_in;
      s2_src_ff  <= s2_src_in;
      s3_dst_ff  <= s3_dst_in;
   end

   assign rsp_valid    = s3_valid_ff;
   assign rsp_dst_bits = s3_dst_ff;

   // Backpressure only when every stage holds a transaction
   a_full_when_stalled: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && s2_valid_ff && s3_valid_ff))
      else $error("input stalled with an empty stage");

   // A transaction moving out of stage 2 lands in the output stage
   a_stage_advance: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && s3_ready) |=> s3_valid_ff)
      else $error("transaction lost between stage 2 and output");

   // fp8 results are zero-extended
   a_fp8_zero_ext: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && s3_ready && (s2_func_ff == FUNC_HF8 || s2_func_ff == FUNC_BF8))
      |=> (s3_dst_ff[31:8] == 24'd0))
      else $error("fp8 result has upper bits set");

   // Unused codes produce zero
   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && s3_ready && (s2_func_ff > FUNC_BF8_UP)) |=> (s3_dst_ff == 32'd0))
      else $error("unused conversion code gave a nonzero result");

endmodule

// File: sv/lpfc_f32_f16.sv
module lpfc_f32_f16 (
   input  logic [31:0] src_bits,
   output logic [15:0] half_bits
);
   import lpfc_pkg::*;

   logic [31:0] x;
   logic [7:0]  ex;
   logic [22:0] fr;
   logic [7:0]  sh_full;
   logic [3:0]  sh;
   logic [23:0] sv;
   logic [23:0] rnd;
   logic [31:0] t;
   logic [7:0]  e2;
   logic [14:0] mag;

   // Flush denormals, then round to nearest even into fp16
   always_comb begin
      x  = (src_bits[30:23] == 8'd0) ? {src_bits[31], 31'd0} : src_bits;
      ex = x[30:23];
      fr = x[22:0];

      // subnormal result: align mantissa, keep sticky, round at bit 13
      sh_full = (F16_EXP_SUB + 8'd1) - ex;
      sh      = sh_full[3:0];
      sv      = {1'b1, fr} >> sh;
      sv[0]   = sv[0] | (|fr[12:0]);
      rnd     = sv + 24'h000fff + {23'd0, sv[13]};

      // normal result: round in place, rebias exponent
      t  = x + 32'h0000_0fff + {31'd0, fr[13]};
      e2 = t[30:23] - F16_EXP_SUB;

      if (ex == 8'hff) begin
         mag = {5'h1f, (fr == 23'd0) ? 10'd0 : (fr[22:13] | F16_QUIET_BIT)};
      end else if (ex > F16_EXP_OVF) begin
         mag = {5'h1f, 10'd0};
      end else if (ex < F16_EXP_ZERO) begin
         mag = 15'd0;
      end else if (ex <= F16_EXP_SUB) begin
         mag = {4'd0, rnd[23:13]};
      end else begin
         mag = {e2[4:0], t[22:13]};
      end

      half_bits = {x[31], mag};
   end

endmodule

// File: sv/lpfc_narrow.sv
module lpfc_narrow (
   input  lpfc_pkg::lpfc_func_type func,
   input  logic [31:0]             wide_bits,
   input  logic [15:0]             half_bits,
   input  logic [15:0]             src_low,
   output logic [31:0]             dst_bits
);
   import lpfc_pkg::*;

   // fp16 -> E4M3, round to nearest even, NaN on overflow
   function automatic logic [7:0] f16_to_hf8(input logic [15:0] h);
      logic [4:0]  ex;
      logic [9:0]  fr;
      logic [4:0]  sh_full;
      logic [10:0] sv;
      logic [11:0] rnd;
      logic [15:0] t;
      logic [4:0]  e;
      logic [6:0]  mag;
      ex      = h[14:10];
      fr      = h[9:0];
      sh_full = (HF8_EXP_SUB + 5'd1) - ex;
      sv      = {1'b1, fr} >> sh_full[2:0];
      if (sh_full[3]) begin
         sv = {1'b1, fr} >> 4'd8;
      end
      sv[0]   = sv[0] | (|fr[6:0]);
      rnd     = {1'b0, sv} + 12'h03f + {11'd0, sv[7]};
      t       = h + 16'h003f + {15'd0, fr[7]};
      e       = t[14:10] - HF8_EXP_SUB;
      if (ex == 5'h1f || ex > HF8_EXP_OVF || (ex == HF8_EXP_OVF && fr > HF8_FR_MAX)) begin
         mag = 7'h7f;
      end else if (ex < HF8_EXP_ZERO) begin
         mag = 7'd0;
      end else if (ex <= HF8_EXP_SUB) begin
         mag = {3'd0, rnd[10:7]};
      end else begin
         mag = {e[3:0], t[9:7]};
      end
      return {h[15], mag};
   endfunction

   // fp16 -> E5M2, round to nearest even, quiet NaNs
   function automatic logic [7:0] f16_to_bf8(input logic [15:0] h);
      logic [15:0] t;
      if (h[14:10] == 5'h1f) begin
         t = (h[9:0] == 10'd0) ? h : (h | {6'd0, F16_QUIET_BIT});
      end else begin
         t = h + 16'h007f + {15'd0, h[8]};
      end
      return t[15:8];
   endfunction

   // fp16 -> fp32 with subnormal normalization
   function automatic logic [31:0] f16_to_f32(input logic [15:0] h);
      logic [4:0] ex;
      logic [9:0] m;
      logic [7:0] en;
      logic [3:0] lz;
      ex = h[14:10];
      m  = h[9:0];
      en = {3'd0, ex} + (SGL_EXP_BIAS - HALF_EXP_BIAS);
      lz = 4'd9;
      for (int i = 0; i < 10; i++) begin
         if (m[i]) begin
            lz = 4'(9 - i);
         end
      end
      if (ex == 5'd0 && m != 10'd0) begin
         en = en - {4'd0, lz};
         m  = m << (lz + 4'd1);
      end else if (ex == 5'd0) begin
         en = 8'd0;
      end else if (ex == 5'h1f) begin
         en = 8'hff;
         if (m != 10'd0) begin
            m = m | F16_QUIET_BIT;
         end
      end
      return {h[15], en, m, 13'd0};
   endfunction

   // E4M3 -> fp32; only the all-ones code is NaN
   function automatic logic [31:0] hf8_to_f32(input logic [7:0] b);
      logic [3:0] ex;
      logic [2:0] m;
      logic [7:0] en;
      logic [1:0] lz;
      ex = b[6:3];
      m  = b[2:0];
      en = {4'd0, ex} + (SGL_EXP_BIAS - HF8_BIAS);
      lz = (m > 3'd3) ? 2'd0 : ((m > 3'd1) ? 2'd1 : 2'd2);
      if (ex == 4'd0 && m != 3'd0) begin
         en = en - {6'd0, lz};
         m  = m << (lz + 2'd1);
      end else if (ex == 4'd0) begin
         en = 8'd0;
      end else if (ex == 4'hf && m == 3'h7) begin
         en = 8'hff;
         m  = 3'h4;
      end
      return {b[7], en, m, 20'd0};
   endfunction

   // Second half of the conversion, selected by code
   always_comb begin
      case (func)
         FUNC_BF16_TRUNC, FUNC_BF16_HALF, FUNC_BF16_RNE, FUNC_BF16_UP: begin
            dst_bits = wide_bits;
         end
         FUNC_F16_RNE: dst_bits = {16'd0, half_bits};
         FUNC_HF8:     dst_bits = {24'd0, f16_to_hf8(half_bits)};
         FUNC_BF8:     dst_bits = {24'd0, f16_to_bf8(half_bits)};
         FUNC_F16_UP:  dst_bits = f16_to_f32(src_low);
         FUNC_HF8_UP:  dst_bits = hf8_to_f32(src_low[7:0]);
         FUNC_BF8_UP:  dst_bits = f16_to_f32({src_low[7:0], 8'd0});
         default:      dst_bits = 32'd0;
      endcase
   end

endmodule
